[hdl/gsr_pkg.sv]
// Shared widths, register indexes and operation codes of the grid stream reducer.
package gsr_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam int CELL_W     = 32;
    localparam int MODE_W     = 4;
    localparam int DIM_REG_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [MODE_W-1:0]    mode_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_MODE = 2'd0;
    localparam cfg_idx_t REG_ROWS = 2'd1;
    localparam cfg_idx_t REG_COLS = 2'd2;

    // Fold operations
    localparam mode_t MODE_MAX  = 4'd0;
    localparam mode_t MODE_MIN  = 4'd1;
    localparam mode_t MODE_SUM  = 4'd2;
    localparam mode_t MODE_PROD = 4'd3;
    localparam mode_t MODE_LAND = 4'd4;
    localparam mode_t MODE_BAND = 4'd5;
    localparam mode_t MODE_LOR  = 4'd6;
    localparam mode_t MODE_BOR  = 4'd7;
    localparam mode_t MODE_LXOR = 4'd8;
    localparam mode_t MODE_BXOR = 4'd9;

endpackage

[hdl/grid_stream_reducer_unit.sv]
// Grid stream reducer: folds a rows-by-columns grid of cells into one value.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  s_       | in        | s_tvalid / s_tready    | s_tdata[31:0] = cell_value
//  m_       | out       | m_tvalid / m_tready    | m_tdata[31:0] = reduced_value
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (13 bits)
//
// Cycles: one cell per cycle unless s_tready is held low; the cell that closes a
//   grid passes the input register, then is folded into the result register for m_.
// Cell count rows*cols is a registered 13x13 product, refreshed every cycle.
// Reset: mode max, 1x1 grid, accumulator and seen-cell counter cleared; no clearing pass.
// Stalls: s_tready drops only while the input register holds a grid-closing
//   cell and the result register is full and not being taken.
// cfg_ready is always high; writes beyond the register list are dropped.
module grid_stream_reducer_unit #(
    parameter int MAX_DIM = gsr_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata bits from lowest: cell_value[31:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gsr_pkg::CELL_W-1:0]    s_tdata,
    // m_tdata bits from lowest: reduced_value[31:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsr_pkg::CELL_W-1:0]    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gsr_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) + 1);

    // Configuration registers
    logic [MODE_W-1:0]    mode_reg;
    logic [DIM_REG_W-1:0] rows_reg;
    logic [DIM_REG_W-1:0] cols_reg;

    // Cell count of one grid
    logic [DIM_W-1:0]   rows_clamped;
    logic [DIM_W-1:0]   cols_clamped;
    logic [2*DIM_W-1:0] total_prod;
    logic [CNT_W-1:0]   total_reg;

    // Input register
    logic              in_valid_reg;
    logic [CELL_W-1:0] cell_reg;

    // Accumulator and position in the grid
    logic [CELL_W-1:0] acc_reg;
    logic [CELL_W-1:0] acc_next;
    logic [CNT_W-1:0]  seen_reg;
    logic [CNT_W-1:0]  seen_inc;
    logic              grid_done;
    logic              advance;

    // Result register
    logic              out_valid_reg;
    logic [CELL_W-1:0] out_data_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end
        else if (32'(v) > 32'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] fold(
        input logic [MODE_W-1:0] op,
        input logic [CELL_W-1:0] acc,
        input logic [CELL_W-1:0] cell_in
    );
        logic [CELL_W-1:0] r;
        logic [CELL_W-1:0] prod;
        prod = acc * cell_in;
        case (op)
            MODE_MAX:  r = ($signed(cell_in) > $signed(acc)) ? cell_in : acc;
            MODE_MIN:  r = ($signed(cell_in) < $signed(acc)) ? cell_in : acc;
            MODE_SUM:  r = acc + cell_in;
            MODE_PROD: r = prod;
            MODE_LAND: r = CELL_W'((acc != '0) && (cell_in != '0));
            MODE_BAND: r = acc & cell_in;
            MODE_LOR:  r = CELL_W'((acc != '0) || (cell_in != '0));
            MODE_BOR:  r = acc | cell_in;
            MODE_LXOR: r = CELL_W'((acc != '0) != (cell_in != '0));
            MODE_BXOR: r = acc ^ cell_in;
            default:   r = acc;
        endcase
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MAX;
            rows_reg <= DIM_REG_W'(1);
            cols_reg <= DIM_REG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                REG_ROWS: rows_reg <= cfg_data[DIM_REG_W-1:0];
                REG_COLS: cols_reg <= cfg_data[DIM_REG_W-1:0];
                default:  ;
            endcase
        end
    end

    // Refresh the registered cell count from the dimension registers
    assign rows_clamped = clamp_dim(rows_reg);
    assign cols_clamped = clamp_dim(cols_reg);
    assign total_prod   = rows_clamped * cols_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= CNT_W'(1);
        end
        else
        begin
            total_reg <= CNT_W'(total_prod);
        end
    end

    // Seed on the first cell, fold afterwards; close the grid at the count
    assign acc_next  = (seen_reg == '0) ? cell_reg : fold(mode_reg, acc_reg, cell_reg);
    assign seen_inc  = seen_reg + CNT_W'(1);
    assign grid_done = (seen_inc >= total_reg);

    // Hold a grid-closing cell only while the result slot stays occupied
    assign advance  = in_valid_reg && (!grid_done || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cell_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            seen_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            seen_reg <= grid_done ? '0 : seen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && grid_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && grid_done)
        begin
            out_data_reg <= acc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && grid_done) |=> (seen_reg == '0))
        else $error("cell count not rearmed after grid end");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && grid_done && out_valid_reg && !m_tready))
        else $error("input stalled without a full result slot");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != '0)
        else $error("grid cell count is zero");

    a_logic_bool: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (seen_reg != '0) &&
         (mode_reg == MODE_LAND || mode_reg == MODE_LOR || mode_reg == MODE_LXOR))
        |=> (acc_reg[CELL_W-1:1] == '0))
        else $error("logical fold produced a value other than 0 or 1");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && grid_done) |=> (m_tvalid && (m_tdata == $past(acc_next))))
        else $error("result register not loaded at grid end");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for the grid stream reducer: folds, grid sizes and live reconfiguration.
module tb_top;

    import gsr_pkg::*;

    typedef logic [CELL_W-1:0]     cell_t;
    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    // Index past the register list; the block drops writes to it
    localparam cfg_idx_t REG_SPARE   = 2'd3;
    localparam int       DRAIN_CYCLES = 6;
    localparam int       CYCLE_LIMIT  = 1000000;
    localparam int       MAX_GRID_PROBE = 40;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      s_tvalid;
    logic      s_tready;
    cell_t     s_tdata;
    logic      m_tvalid;
    logic      m_tready;
    cell_t     m_tdata;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_word_t cfg_data;

    int src_gap_pct;
    int sink_stall_pct;
    int fail_count  = 0;
    int cycle_count = 0;

    // Predictor copy of the registers and the running grid
    mode_t     grid_mode     = MODE_MAX;
    cfg_word_t grid_rows_reg = 1;
    cfg_word_t grid_cols_reg = 1;
    cell_t     grid_acc      = '0;
    longint    grid_seen     = 0;
    cell_t     due_reductions[$];

    grid_stream_reducer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver side: stall at the rate of the current phase
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic int clamp_dim(cfg_word_t v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM_DEFAULT)
            return MAX_DIM_DEFAULT;
        return int'(v);
    endfunction

    function automatic int grid_cells(cfg_word_t rows, cfg_word_t cols);
        return clamp_dim(rows) * clamp_dim(cols);
    endfunction

    function automatic cell_t fold_cell(mode_t op, cell_t acc, cell_t c);
        case (op)
            MODE_MAX:  return ($signed(c) > $signed(acc)) ? c : acc;
            MODE_MIN:  return ($signed(c) < $signed(acc)) ? c : acc;
            MODE_SUM:  return acc + c;
            MODE_PROD: return acc * c;
            MODE_LAND: return ((acc != '0) && (c != '0)) ? 1 : 0;
            MODE_BAND: return acc & c;
            MODE_LOR:  return ((acc != '0) || (c != '0)) ? 1 : 0;
            MODE_BOR:  return acc | c;
            MODE_LXOR: return ((acc != '0) != (c != '0)) ? 1 : 0;
            MODE_BXOR: return acc ^ c;
            default:   return acc;
        endcase
    endfunction

    // Seed on the first cell, fold the rest; close once the count is reached or passed
    function automatic void absorb_cell(cell_t c);
        if (grid_seen == 0)
            grid_acc = c;
        else
            grid_acc = fold_cell(grid_mode, grid_acc, c);
        grid_seen++;
        if (grid_seen >= grid_cells(grid_rows_reg, grid_cols_reg))
        begin
            due_reductions.push_back(grid_acc);
            grid_seen = 0;
        end
    endfunction

    task automatic report_mismatch(string what, cell_t got, cell_t want);
        fail_count++;
        $display("tb_top: %s at cycle %0d: got %08h, want %08h", what, cycle_count, got, want);
    endtask

    // Check results first, then track register writes and cell requests
    always @(posedge clk)
    begin : scoreboard
        cell_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_reductions.size() == 0)
                    report_mismatch("unexpected reduced_value", m_tdata, '0);
                else
                begin
                    want = due_reductions.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("reduced_value mismatch", m_tdata, want);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE: grid_mode     = cfg_data[MODE_W-1:0];
                    REG_ROWS: grid_rows_reg = cfg_data;
                    REG_COLS: grid_cols_reg = cfg_data;
                    default:  ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_cell(s_tdata);
        end
    end

    function automatic cell_t random_cell();
        case ($urandom_range(11))
            0, 1:    return '0;
            2:       return 1;
            3:       return '1;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h8000_0000;
            6:       return $urandom_range(0, 15);
            7:       return 0 - $urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    // Mostly real operations, some unknown codes, some junk in the upper bits
    function automatic cfg_word_t random_mode_word();
        cfg_word_t w;
        if ($urandom_range(9) == 0)
            w = cfg_word_t'($urandom_range(10, 15));
        else
            w = cfg_word_t'($urandom_range(MODE_MAX, MODE_BXOR));
        if ($urandom_range(7) == 0)
            w = w | cfg_word_t'($urandom() & 32'h0000_1FF0);
        return w;
    endfunction

    function automatic cfg_word_t random_dim();
        if ($urandom_range(9) == 0)
            return '0;
        return cfg_word_t'($urandom_range(1, 5));
    endfunction

    // Send one cell request; valid stays high into the next call unless it idles
    task automatic push_cell(cell_t v);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_cells(int n);
        for (int i = 0; i < n; i++)
            push_cell(random_cell());
    endtask

    // Drop valid, drain all pending results, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_reductions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_word_t data, bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(cfg_word_t mode_word, cfg_word_t rows, cfg_word_t cols);
        settle();
        write_reg(REG_MODE, mode_word, 1'b1);
        write_reg(REG_ROWS, rows, 1'b1);
        write_reg(REG_COLS, cols, 1'b0);
    endtask

    // Reset state: max over a 1x1 grid, so every cell comes straight back
    task automatic test_reset_defaults();
        push_cell(32'h7FFF_FFFF);
        push_cell(32'h8000_0000);
    endtask

    // One two-cell grid per operation, values picked to expose sign and wrap
    task automatic test_fold_ops();
        cell_t a;
        cell_t b;
        for (int op = MODE_MAX; op <= MODE_BXOR; op++)
        begin
            case (op)
                MODE_MAX:  begin a = 32'h8000_0000; b = 32'h7FFF_FFFF; end
                MODE_MIN:  begin a = 32'h7FFF_FFFF; b = 32'h8000_0000; end
                MODE_SUM:  begin a = 32'h7FFF_FFFF; b = 32'h0000_0001; end
                MODE_PROD: begin a = 32'h8000_0000; b = 32'hFFFF_FFFF; end
                MODE_LAND: begin a = 32'hFFFF_FFFF; b = 32'h0000_0000; end
                MODE_BAND: begin a = 32'hF0F0_F0F0; b = 32'h3C3C_3C3C; end
                MODE_LOR:  begin a = 32'h0000_0000; b = 32'h8000_0000; end
                MODE_BOR:  begin a = 32'h0F0F_0F0F; b = 32'h8000_0000; end
                MODE_LXOR: begin a = 32'h0000_0001; b = 32'hFFFF_FFFF; end
                default:   begin a = 32'hAAAA_AAAA; b = 32'h5555_5555; end
            endcase
            set_grid(cfg_word_t'(op), 1, 2);
            push_cell(a);
            push_cell(b);
        end
    endtask

    // Unknown mode keeps the seed; zero rows clamp to one
    task automatic test_unknown_mode_and_clamp();
        set_grid(13'h1F0F, 0, 2);
        push_cell(32'h1234_5678);
        push_cell(32'hFFFF_FFFF);
    endtask

    // Start a huge grid, then shrink it below the cells seen and switch the fold
    task automatic test_mid_grid_change();
        set_grid(cfg_word_t'(MODE_SUM), cfg_word_t'(MAX_DIM_DEFAULT),
                 cfg_word_t'(MAX_DIM_DEFAULT));
        push_cell(32'h7FFF_FFFF);
        push_cell(32'h7FFF_FFFF);
        settle();
        write_reg(REG_SPARE, '1, 1'b0);
        set_grid(cfg_word_t'(MODE_PROD), 1, 1);
        push_cell(32'h0000_0003);
    endtask

    // Oversized rows saturate and zero columns clamp: the grid stays open, then a 1x1 closes it
    task automatic test_max_grid();
        set_grid(cfg_word_t'(MODE_SUM), '1, '0);
        send_cells(MAX_GRID_PROBE);
        set_grid(cfg_word_t'(MODE_SUM), 1, 1);
        push_cell(32'h0000_0005);
    endtask

    task automatic test_random_traffic(int quota);
        int        sent;
        int        kind;
        int        k;
        int        total;
        cfg_word_t rows;
        cfg_word_t cols;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(19);
            if (kind == 0)
            begin
                rows = $urandom_range(1) ? cfg_word_t'(MAX_DIM_DEFAULT)
                                         : cfg_word_t'($urandom_range(4097, 8191));
                cols = cfg_word_t'($urandom_range(2, 8191));
            end
            else
            begin
                rows = random_dim();
                cols = random_dim();
            end
            set_grid(random_mode_word(), rows, cols);
            total = grid_cells(rows, cols);
            // Cut the grid short and reconfigure while it is partly full
            if (kind < 4 && total > 1)
            begin
                k = (kind == 0) ? $urandom_range(1, 6) : $urandom_range(1, total - 1);
                send_cells(k);
                sent += k;
                rows = random_dim();
                cols = random_dim();
                set_grid(random_mode_word(), rows, cols);
                total = grid_cells(rows, cols);
                total = (total > k) ? total - k : 1;
            end
            send_cells(total);
            sent += total;
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_data  <= '0;
        src_gap_pct    = 32;
        sink_stall_pct = 69;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_fold_ops();
        test_unknown_mode_and_clamp();
        test_mid_grid_change();
        test_max_grid();
        test_random_traffic(495);

        src_gap_pct    = 69;
        sink_stall_pct = 32;
        test_random_traffic(495);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_traffic(490);

        settle();
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[grid_stream_reducer_unit.f]
hdl/gsr_pkg.sv
hdl/grid_stream_reducer_unit.sv
bench/tb_top.sv
